// ===== hw/rtl/mono_page_frame_buffer_draw_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef MONO_PAGE_FRAME_BUFFER_DRAW_MACROS_SVH
`define MONO_PAGE_FRAME_BUFFER_DRAW_MACROS_SVH

// Same-cycle implication.
`define MPFB_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MPFB_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/mpfb_pkg.sv =====
`default_nettype none
package mpfb_pkg;

   localparam logic [2:0] MODE_SET    = 3'd0;
   localparam logic [2:0] MODE_CLEAR  = 3'd1;
   localparam logic [2:0] MODE_INVERT = 3'd2;
   localparam logic [2:0] MODE_CHAR   = 3'd3;
   localparam logic [2:0] MODE_READ   = 3'd4;

   localparam logic [1:0] OP_SET    = 2'd0;
   localparam logic [1:0] OP_CLEAR  = 2'd1;
   localparam logic [1:0] OP_INVERT = 2'd2;

   localparam logic [6:0] CHAR_MASK    = 7'h7f;
   localparam logic [6:0] CODE_NEWLINE = 7'd10;
   localparam logic [6:0] CODE_FIRST   = 7'd32;
   localparam logic [3:0] PAGE_SAT     = 4'd15;
   localparam logic [8:0] COLUMN_SAT   = 9'd511;
   localparam logic [2:0] GLYPH_BYTES  = 3'd5;

   localparam logic [0:0] REG_COLUMNS = 1'b0;
   localparam logic [0:0] REG_PAGES   = 1'b1;

   typedef enum logic [1:0] {
      CMD_NOP,
      CMD_RECT,
      CMD_CHAR,
      CMD_READ
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [1:0]   op;
      logic [6:0]   x_first;
      logic [6:0]   x_last;
      logic [2:0]   pg_first;
      logic [2:0]   pg_last;
      logic [2:0]   pg_top;
      logic [2:0]   y_lo;
      logic [2:0]   y_hi;
      logic [3:0]   page;
      logic [8:0]   column;
      logic [2:0]   count;
      logic [6:0]   glyph;
      logic         dropped;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_stat_type;

   typedef enum logic [2:0] {
      B_CLEAR,
      B_IDLE,
      B_RECT_RD,
      B_RECT_WR,
      B_CHAR,
      B_READ_RD,
      B_READ_DATA,
      B_DONE
   } back_state_type;

   // 5x7 font, column 0 in the top byte.
   localparam logic [39:0] FONT [0:95] = '{
      40'h0000000000, 40'h00004f0000, 40'h0007000700, 40'h147f147f14,
      40'h242a7f2a12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
      40'h001c224100, 40'h0041221c00, 40'h14083e0814, 40'h08083e0808,
      40'h0050300000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
      40'h3e5149453e, 40'h00427f4000, 40'h4261514946, 40'h2141454b31,
      40'h1814127f10, 40'h2745454539, 40'h3c4a494930, 40'h0171090503,
      40'h3649494936, 40'h064949291e, 40'h0036360000, 40'h0056360000,
      40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
      40'h324979413e, 40'h7e1111117e, 40'h7f49494936, 40'h3e41414122,
      40'h7f4141221c, 40'h7f49494941, 40'h7f09090901, 40'h3e4149497a,
      40'h7f0808087f, 40'h00417f4100, 40'h2040413f01, 40'h7f08142241,
      40'h7f40404040, 40'h7f020c027f, 40'h7f0408107f, 40'h3e4141413e,
      40'h7f09090906, 40'h3e4151215e, 40'h7f09192946, 40'h4649494931,
      40'h01017f0101, 40'h3f4040403f, 40'h1f2040201f, 40'h3f4038403f,
      40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007f414100,
      40'h0204081020, 40'h0041417f00, 40'h0402010204, 40'h4040404040,
      40'h0001020400, 40'h2054545478, 40'h7f48444438, 40'h3844444420,
      40'h384444487f, 40'h3854545418, 40'h087e090102, 40'h0c5252523e,
      40'h7f08040478, 40'h00447d4000, 40'h2040443d00, 40'h7f10284400,
      40'h00417f4000, 40'h7c04180478, 40'h7c08040478, 40'h3844444438,
      40'h7c14141408, 40'h081414187c, 40'h7c08040408, 40'h4854545420,
      40'h043f444020, 40'h3c4040207c, 40'h1c2040201c, 40'h3c4030403c,
      40'h4428102844, 40'h0c5050503c, 40'h4464544c44, 40'h0008364100,
      40'h00007f0000, 40'h0041360800, 40'h0201020402, 40'h0000000000
   };

   function automatic logic [7:0] glyph_byte(input logic [6:0] g, input logic [2:0] n);
      logic [39:0] row;
      row = FONT[g];
      return row[8 * (3'd4 - n) +: 8];
   endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/mpfb_ram.sv =====
`default_nettype none
module mpfb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_front.sv =====
`default_nettype none
module mpfb_front #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_tvalid,
   output logic                  req_tready,
   input  wire logic [2:0]       mode,
   input  wire logic [6:0]       x_start,
   input  wire logic [5:0]       y_start,
   input  wire logic [6:0]       x_end,
   input  wire logic [5:0]       y_end,
   input  wire logic [7:0]       char_code,
   input  wire logic             new_string,
   input  wire logic [2:0]       page,
   input  wire logic [6:0]       column,
   input  wire logic [7:0]       columns_in_use,
   input  wire logic [3:0]       pages_in_use,
   input  wire logic             can_push,
   output logic                  push,
   output mpfb_pkg::cmd_type     cmd
);
   import mpfb_pkg::*;

   logic [3:0] cursor_page_ff, cursor_page_in;
   logic [8:0] cursor_column_ff, cursor_column_in;
   logic [6:0] line_start_ff, line_start_in;

   logic [8:0] eff_cols;
   logic [4:0] eff_pages;
   logic [2:0] ps, pe;
   logic       rect_empty, x_any, p_any;
   logic [3:0] cp;
   logic [8:0] cc, rem;
   logic [6:0] ls, code;
   logic [9:0] col_sum;
   logic [2:0] cnt;

   assign req_tready = can_push;
   assign push       = req_tvalid && can_push;

   always_comb begin
      eff_cols  = ({1'b0, columns_in_use} > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS)
                                                             : {1'b0, columns_in_use};
      eff_pages = ({1'b0, pages_in_use} > 5'(MAX_PAGES)) ? 5'(MAX_PAGES)
                                                         : {1'b0, pages_in_use};
      ps = y_start[5:3];
      pe = y_end[5:3];
      rect_empty = (x_start > x_end) || (y_start > y_end);
      x_any = (eff_cols != 9'd0) && ({2'b0, x_start} < eff_cols);
      p_any = ({2'b0, ps} < eff_pages);

      code = char_code[6:0] & CHAR_MASK;
      cp = new_string ? {1'b0, page} : cursor_page_ff;
      cc = new_string ? {2'b0, column} : cursor_column_ff;
      ls = new_string ? column : line_start_ff;
      col_sum = {1'b0, cc} + 10'(GLYPH_BYTES);
      rem = eff_cols - cc;
      if (({1'b0, cp} >= eff_pages) || (cc >= eff_cols)) begin
         cnt = 3'd0;
      end else if (rem > 9'(GLYPH_BYTES)) begin
         cnt = GLYPH_BYTES;
      end else begin
         cnt = rem[2:0];
      end

      cmd          = '0;
      cmd.kind     = CMD_NOP;
      cmd.op       = mode[1:0];
      cmd.x_first  = x_start;
      cmd.x_last   = ({2'b0, x_end} < eff_cols) ? x_end : 7'(eff_cols - 9'd1);
      cmd.pg_first = ps;
      cmd.pg_last  = ({2'b0, pe} < eff_pages) ? pe : 3'(eff_pages - 5'd1);
      cmd.pg_top   = pe;
      cmd.y_lo     = y_start[2:0];
      cmd.y_hi     = y_end[2:0];
      cmd.page     = {1'b0, page};
      cmd.column   = {2'b0, column};
      cmd.count    = cnt;
      cmd.glyph    = (code < CODE_FIRST) ? 7'd0 : code - CODE_FIRST;

      cursor_page_in   = cursor_page_ff;
      cursor_column_in = cursor_column_ff;
      line_start_in    = line_start_ff;

      priority if (mode <= MODE_INVERT) begin
         cmd.kind    = (rect_empty || !x_any || !p_any) ? CMD_NOP : CMD_RECT;
         cmd.dropped = !rect_empty
                       && (({2'b0, x_end} >= eff_cols) || ({2'b0, pe} >= eff_pages));
      end else if (mode == MODE_CHAR) begin
         line_start_in = ls;
         if (code == CODE_NEWLINE) begin
            cursor_page_in   = (cp < PAGE_SAT) ? cp + 4'd1 : cp;
            cursor_column_in = {2'b0, ls};
         end else begin
            cmd.kind    = (cnt == 3'd0) ? CMD_NOP : CMD_CHAR;
            cmd.page    = cp;
            cmd.column  = cc;
            cmd.dropped = (cnt != GLYPH_BYTES);
            cursor_page_in   = cp;
            cursor_column_in = (col_sum > {1'b0, COLUMN_SAT}) ? COLUMN_SAT : col_sum[8:0];
         end
      end else if (mode == MODE_READ) begin
         if (({2'b0, page} < eff_pages) && ({2'b0, column} < eff_cols)) begin
            cmd.kind = CMD_READ;
         end else begin
            cmd.dropped = 1'b1;
         end
      end else begin
         cmd.kind = CMD_NOP;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_page_ff   <= '0;
         cursor_column_ff <= '0;
         line_start_ff    <= '0;
      end else if (push && (mode == MODE_CHAR)) begin
         cursor_page_ff   <= cursor_page_in;
         cursor_column_ff <= cursor_column_in;
         line_start_ff    <= line_start_in;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_cmdq.sv =====
`default_nettype none
module mpfb_cmdq (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 push,
   input  wire mpfb_pkg::cmd_type    push_data,
   input  wire logic                 pop,
   output mpfb_pkg::cmd_type         pop_data,
   output mpfb_pkg::q_stat_type      stat
);
   import mpfb_pkg::*;

   cmd_type    slot_ff [2];
   logic       wr_ff, wr_in, rd_ff, rd_in;
   logic [1:0] count_ff, count_in;

   always_comb begin
      wr_in    = push ? ~wr_ff : wr_ff;
      rd_in    = pop ? ~rd_ff : rd_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   assign pop_data   = slot_ff[rd_ff];
   assign stat.full  = (count_ff == 2'd2);
   assign stat.empty = (count_ff == 2'd0);

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= 1'b0;
         rd_ff    <= 1'b0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

// ===== hw/rtl/mpfb_back.sv =====
`default_nettype none
module mpfb_back #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8
) (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire mpfb_pkg::q_stat_type                   q_stat,
   input  wire mpfb_pkg::cmd_type                      q_data,
   output logic                                        pop,
   output logic                                        clearing,
   output logic                                        ram_we,
   output logic [$clog2(MAX_COLUMNS*MAX_PAGES)-1:0]    ram_waddr,
   output logic [7:0]                                  ram_wdata,
   output logic [$clog2(MAX_COLUMNS*MAX_PAGES)-1:0]    ram_raddr,
   input  wire logic [7:0]                             ram_rdata,
   output logic                                        rsp_valid,
   input  wire logic                                   rsp_ready,
   output logic [7:0]                                  rsp_read_data,
   output logic                                        rsp_status
);
   import mpfb_pkg::*;

   localparam int DEPTH = MAX_COLUMNS * MAX_PAGES;
   localparam int AW    = $clog2(DEPTH);

   back_state_type state_ff, state_in;
   cmd_type        cmd_ff, cmd_in;
   logic [6:0]     x_ff, x_in;
   logic [2:0]     p_ff, p_in;
   logic [2:0]     n_ff, n_in;
   logic [AW-1:0]  clr_ff, clr_in;
   logic [7:0]     rd_ff, rd_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [7:0]     rsp_data_ff, rsp_data_in;
   logic           rsp_status_ff, rsp_status_in;

   logic          out_free, rect_last;
   logic [2:0]    lo, hi;
   logic [7:0]    mask, modified;
   logic [AW-1:0] rect_addr, char_addr, read_addr;

   always_comb begin
      out_free  = !rsp_valid_ff || rsp_ready;
      rect_last = (x_ff == cmd_ff.x_last) && (p_ff == cmd_ff.pg_last);
      lo   = (p_ff == cmd_ff.pg_first) ? cmd_ff.y_lo : 3'd0;
      hi   = (p_ff == cmd_ff.pg_top) ? cmd_ff.y_hi : 3'd7;
      mask = (8'hff << lo) & (8'hff >> (3'd7 - hi));
      unique case (cmd_ff.op)
         OP_SET:    modified = ram_rdata | mask;
         OP_CLEAR:  modified = ram_rdata & ~mask;
         default:   modified = ram_rdata ^ mask;
      endcase
      rect_addr = AW'(32'(p_ff) * MAX_COLUMNS + 32'(x_ff));
      char_addr = AW'(32'(cmd_ff.page) * MAX_COLUMNS + 32'(cmd_ff.column) + 32'(n_ff));
      read_addr = AW'(32'(cmd_ff.page) * MAX_COLUMNS + 32'(cmd_ff.column));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_CLEAR:     if (clr_ff == AW'(DEPTH - 1)) state_in = B_IDLE;
         B_IDLE: begin
            if (!q_stat.empty) begin
               unique case (q_data.kind)
                  CMD_RECT: state_in = B_RECT_RD;
                  CMD_CHAR: state_in = B_CHAR;
                  CMD_READ: state_in = B_READ_RD;
                  default:  state_in = B_DONE;
               endcase
            end
         end
         B_RECT_RD:   state_in = B_RECT_WR;
         B_RECT_WR:   state_in = rect_last ? B_DONE : B_RECT_RD;
         B_CHAR:      if (n_ff == cmd_ff.count - 3'd1) state_in = B_DONE;
         B_READ_RD:   state_in = B_READ_DATA;
         B_READ_DATA: state_in = B_DONE;
         B_DONE:      if (out_free) state_in = B_IDLE;
         default:     state_in = B_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      pop       = (state_ff == B_IDLE) && !q_stat.empty;
      clearing  = (state_ff == B_CLEAR);
      ram_we    = 1'b0;
      ram_waddr = rect_addr;
      ram_wdata = modified;
      ram_raddr = rect_addr;
      unique case (state_ff)
         B_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = 8'h00;
         end
         B_RECT_WR: ram_we = 1'b1;
         B_CHAR: begin
            ram_we    = 1'b1;
            ram_waddr = char_addr;
            ram_wdata = glyph_byte(cmd_ff.glyph, n_ff);
         end
         B_READ_RD: ram_raddr = read_addr;
         default: ram_we = 1'b0;
      endcase
   end

   // datapath
   always_comb begin
      cmd_in        = cmd_ff;
      x_in          = x_ff;
      p_in          = p_ff;
      n_in          = n_ff;
      clr_in        = clr_ff;
      rd_in         = rd_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_data_in   = rsp_data_ff;
      rsp_status_in = rsp_status_ff;
      unique case (state_ff)
         B_CLEAR: clr_in = clr_ff + AW'(1);
         B_IDLE: begin
            cmd_in = q_data;
            x_in   = q_data.x_first;
            p_in   = q_data.pg_first;
            n_in   = 3'd0;
            rd_in  = 8'h00;
         end
         B_RECT_WR: begin
            if (x_ff == cmd_ff.x_last) begin
               x_in = cmd_ff.x_first;
               p_in = p_ff + 3'd1;
            end else begin
               x_in = x_ff + 7'd1;
            end
         end
         B_CHAR:      n_in  = n_ff + 3'd1;
         B_READ_DATA: rd_in = ram_rdata;
         B_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_data_in   = rd_ff;
               rsp_status_in = cmd_ff.dropped;
            end
         end
         default: n_in = n_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cmd_ff        <= cmd_in;
      x_ff          <= x_in;
      p_ff          <= p_in;
      n_ff          <= n_in;
      rd_ff         <= rd_in;
      rsp_data_ff   <= rsp_data_in;
      rsp_status_ff <= rsp_status_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_status    = rsp_status_ff;
endmodule
`default_nettype wire

// ===== hw/rtl/mono_page_frame_buffer_draw.sv =====
`default_nettype none
`include "mono_page_frame_buffer_draw_macros.svh"
// Monochrome page frame buffer with drawing: MAX_PAGES pages of MAX_COLUMNS
// bytes, each byte eight vertical pixels (bit b of page p is pixel row 8p+b).
// Each item sets, clears or inverts an inclusive rectangle, writes one 5x7
// character at the text cursor (newline moves to the next page at the line's
// start column), or reads one byte back; exactly one result per item, with
// status 1 when bytes outside the configured panel size were dropped.
// After reset a sweep zeroes all MAX_COLUMNS*MAX_PAGES bytes of the store
// (1024 by default), during which no item is taken; config writes still work.
// Items run one at a time out of a two-entry command queue. A character
// writes its in-range glyph bytes, up to 5; a rectangle reads and then
// rewrites each in-range byte it touches through the frame memory's single
// read-modify-write path.
module mono_page_frame_buffer_draw #(
   parameter int MAX_COLUMNS = 128,
   parameter int MAX_PAGES   = 8
) (
   input  wire logic        clock,
   input  wire logic        reset,
   // req_tdata: x_start[6:0] y_start[12:7] x_end[19:13] y_end[25:20]
   //            char_code[33:26] new_string[34] page[37:35] column[44:38]
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   // req_tuser: mode[2:0]
   input  wire logic [2:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // rsp_tdata: read_data[7:0]
   output logic [7:0]       rsp_tdata,
   // rsp_tuser: status[0]
   output logic             rsp_tuser,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready
);
   import mpfb_pkg::*;

   localparam int AW = $clog2(MAX_COLUMNS * MAX_PAGES);

   logic [7:0]    columns_ff;
   logic [3:0]    pages_ff;
   logic          cfg_write;

   logic          push, pop, can_push, clearing;
   cmd_type       push_cmd, pop_cmd;
   q_stat_type    q_stat;
   logic          ram_we;
   logic [AW-1:0] ram_waddr, ram_raddr;
   logic [7:0]    ram_wdata, ram_rdata;

   // config registers
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      unique case (csr_paddr[2])
         REG_COLUMNS: csr_prdata = {24'b0, columns_ff};
         default:     csr_prdata = {28'b0, pages_ff};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         columns_ff <= 8'd84;
         pages_ff   <= 4'd6;
      end else if (cfg_write) begin
         if (csr_paddr[2] == REG_COLUMNS) begin
            columns_ff <= csr_pwdata[7:0];
         end else begin
            pages_ff <= csr_pwdata[3:0];
         end
      end
   end

   // front end takes items only when the queue has room and the sweep is over
   assign can_push = !q_stat.full && !clearing;

   mpfb_front #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_PAGES  (MAX_PAGES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_tvalid    (req_tvalid),
      .req_tready    (req_tready),
      .mode          (req_tuser),
      .x_start       (req_tdata[6:0]),
      .y_start       (req_tdata[12:7]),
      .x_end         (req_tdata[19:13]),
      .y_end         (req_tdata[25:20]),
      .char_code     (req_tdata[33:26]),
      .new_string    (req_tdata[34]),
      .page          (req_tdata[37:35]),
      .column        (req_tdata[44:38]),
      .columns_in_use(columns_ff),
      .pages_in_use  (pages_ff),
      .can_push      (can_push),
      .push          (push),
      .cmd           (push_cmd)
   );

   mpfb_cmdq u_cmdq (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_cmd),
      .pop      (pop),
      .pop_data (pop_cmd),
      .stat     (q_stat)
   );

   mpfb_back #(
      .MAX_COLUMNS(MAX_COLUMNS),
      .MAX_PAGES  (MAX_PAGES)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_stat       (q_stat),
      .q_data       (pop_cmd),
      .pop          (pop),
      .clearing     (clearing),
      .ram_we       (ram_we),
      .ram_waddr    (ram_waddr),
      .ram_wdata    (ram_wdata),
      .ram_raddr    (ram_raddr),
      .ram_rdata    (ram_rdata),
      .rsp_valid    (rsp_tvalid),
      .rsp_ready    (rsp_tready),
      .rsp_read_data(rsp_tdata),
      .rsp_status   (rsp_tuser)
   );

   mpfb_ram #(
      .WIDTH(8),
      .DEPTH(MAX_COLUMNS * MAX_PAGES)
   ) u_frame (
      .clock(clock),
      .we   (ram_we),
      .waddr(ram_waddr),
      .wdata(ram_wdata),
      .raddr(ram_raddr),
      .rdata(ram_rdata)
   );

   `MPFB_ASSERT_NOW(a_no_take_in_sweep, clock, reset, clearing, !req_tready, "taken in sweep")
   `MPFB_ASSERT_NOW(a_no_push_full, clock, reset, push, !q_stat.full, "push into full queue")
   `MPFB_ASSERT_NOW(a_pop_nonempty, clock, reset, pop, !q_stat.empty, "pop from empty queue")
   `MPFB_ASSERT_NOW(a_drop_zero, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata == '0, "drop data")
   `MPFB_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid, "rsp lost")
endmodule
`default_nettype wire
